/* design/hdlctx_pkg.sv */
// Shared constants, types and the CRC bit step of the HDLC transmit framer.
`timescale 1ns / 1ps
package hdlctx_pkg;

	localparam int unsigned CFG_AW = 8;

	localparam logic [CFG_AW-1:0] REG_ADDRESS = 8'd0;
	localparam logic [CFG_AW-1:0] REG_CONTROL = 8'd1;

	localparam logic [7:0]  FLAG_PATTERN  = 8'h7E;
	localparam logic [15:0] CRC_POLY      = 16'h8005;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [7:0]  ADDRESS_RESET = 8'hFF;
	localparam logic [7:0]  CONTROL_RESET = 8'h03;
	localparam logic [2:0]  STUFF_LIMIT   = 3'd5;

	typedef struct packed {
		logic init;
		logic step;
		logic din;
	} crc_ctrl_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
		logic fb;
		fb = crc[15] ^ b;
		return {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
	endfunction

endpackage

/* design/hdlctx_ifs.sv */
// Handshake channel interfaces of the HDLC transmit framer.
`timescale 1ns / 1ps
interface hdlctx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hdlctx_out_if;
	logic valid;
	logic ready;
	logic line_bit;
	logic frame_end;
	logic run_last;
	modport source (output valid, output line_bit, output frame_end, output run_last,
		input ready);
	modport sink (input valid, input line_bit, input frame_end, input run_last,
		output ready);
endinterface

interface hdlctx_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] addr;
	logic [7:0] wdata;
	modport source (output valid, output addr, output wdata, input ready);
	modport sink (input valid, input addr, input wdata, output ready);
endinterface

/* design/hdlctx_crc16.sv */
// CRC-16 accumulator that advances one line bit per step.
`timescale 1ns / 1ps
module hdlctx_crc16 (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hdlctx_pkg::crc_ctrl_t ctrl,
	output logic [15:0]           crc_nx
);
	import hdlctx_pkg::*;

	logic [15:0] crc_q;

	assign crc_nx = crc_step(crc_q, ctrl.din);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctrl.step) begin
			crc_q <= crc_nx;
		end
	end

endmodule

/* design/hdlc_transmit_framer.sv */
// HDLC transmit framer: bytes in, flag-delimited bit-stuffed serial stream with CRC-16 out.
// Each accepted byte is sent one line bit per cycle through a registered output stage while
// the output is not stalled. The first byte of a frame costs 8 flag bits plus 16
// address/control bits before its own 8 bits; a last byte adds 16 FCS bits and the 8-bit
// closing flag. Every stuffed zero adds one line bit. All bits come from the single bit
// sequencer and its shared CRC bit step. The input is not ready while a byte is being sent.
// Address and control are read as the frame header goes out, so write them only while no
// byte is in flight; writes are taken in every cycle.
`timescale 1ns / 1ps
module hdlc_transmit_framer (
	input  logic clk,
	input  logic arst_n,
	hdlctx_in_if.sink    din,
	hdlctx_out_if.source dout,
	hdlctx_cfg_if.sink   cfg
);
	import hdlctx_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_OPEN  = 3'd1;
	localparam logic [2:0] S_ADDR  = 3'd2;
	localparam logic [2:0] S_CTRL  = 3'd3;
	localparam logic [2:0] S_DATA  = 3'd4;
	localparam logic [2:0] S_FCS   = 3'd5;
	localparam logic [2:0] S_CLOSE = 3'd6;

	logic [2:0]  seg_q;
	logic [3:0]  cnt_q;
	logic [15:0] sh_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        in_frame_q;
	logic [2:0]  ones_q;
	logic        stuff_q;
	logic [7:0]  addr_q;
	logic [7:0]  ctrl_q;
	logic        ov_q;
	logic        obit_q;
	logic        oend_q;
	logic        olast_q;

	logic        accept;
	logic        busy;
	logic        adv;
	logic        cur_bit;
	logic        is_flag;
	logic        is_crc;
	logic [2:0]  ones_nx;
	logic        need_stuff;
	logic        seg_end;
	logic        final_bit;
	logic        end_bit;
	crc_ctrl_t   crc_ctrl;
	logic [15:0] crc_nx;

	assign din.ready  = (seg_q == S_IDLE) && !stuff_q;
	assign accept     = din.valid && din.ready;
	assign busy       = (seg_q != S_IDLE) || stuff_q;
	assign adv        = busy && (!ov_q || dout.ready);
	assign cfg.ready  = 1'b1;

	assign dout.valid     = ov_q;
	assign dout.line_bit  = obit_q;
	assign dout.frame_end = oend_q;
	assign dout.run_last  = olast_q;

	always_comb begin
		cur_bit    = stuff_q ? 1'b0 : sh_q[15];
		is_flag    = (seg_q == S_OPEN) || (seg_q == S_CLOSE);
		is_crc     = (seg_q == S_ADDR) || (seg_q == S_CTRL) || (seg_q == S_DATA);
		ones_nx    = cur_bit ? 3'(ones_q + 3'd1) : 3'd0;
		need_stuff = !stuff_q && !is_flag && (ones_nx == STUFF_LIMIT);
		seg_end    = (cnt_q == 4'd0);
		end_bit    = !stuff_q && (seg_q == S_CLOSE) && seg_end;
		if (stuff_q) begin
			final_bit = (seg_q == S_IDLE);
		end else begin
			final_bit = ((seg_q == S_DATA) && seg_end && !last_q && !need_stuff) || end_bit;
		end
		crc_ctrl.init = accept && !in_frame_q;
		crc_ctrl.step = adv && !stuff_q && is_crc;
		crc_ctrl.din  = cur_bit;
	end

	hdlctx_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.crc_nx (crc_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDRESS_RESET;
			ctrl_q <= CONTROL_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.addr == REG_ADDRESS) begin
				addr_q <= cfg.wdata;
			end else if (cfg.addr == REG_CONTROL) begin
				ctrl_q <= cfg.wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= 1'b1;
		end else if (dout.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			obit_q  <= cur_bit;
			oend_q  <= end_bit;
			olast_q <= final_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q      <= S_IDLE;
			cnt_q      <= 4'd0;
			in_frame_q <= 1'b0;
			ones_q     <= 3'd0;
			stuff_q    <= 1'b0;
		end else if (adv) begin
			if (stuff_q) begin
				stuff_q <= 1'b0;
			end else begin
				if (!is_flag) begin
					ones_q  <= need_stuff ? 3'd0 : ones_nx;
					stuff_q <= need_stuff;
				end
				cnt_q <= cnt_q - 4'd1;
				if (seg_end) begin
					unique case (seg_q)
						S_OPEN: begin
							seg_q <= S_ADDR;
							cnt_q <= 4'd7;
						end
						S_ADDR: begin
							seg_q <= S_CTRL;
							cnt_q <= 4'd7;
						end
						S_CTRL: begin
							seg_q <= S_DATA;
							cnt_q <= 4'd7;
						end
						S_DATA: begin
							if (last_q) begin
								seg_q <= S_FCS;
								cnt_q <= 4'd15;
							end else begin
								seg_q <= S_IDLE;
							end
						end
						S_FCS: begin
							seg_q <= S_CLOSE;
							cnt_q <= 4'd7;
						end
						S_CLOSE: begin
							seg_q      <= S_IDLE;
							in_frame_q <= 1'b0;
							ones_q     <= 3'd0;
						end
						default: begin
							seg_q <= S_IDLE;
						end
					endcase
				end
			end
		end else if (accept) begin
			cnt_q <= 4'd7;
			if (!in_frame_q) begin
				seg_q      <= S_OPEN;
				ones_q     <= 3'd0;
				in_frame_q <= 1'b1;
			end else begin
				seg_q <= S_DATA;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= din.data_byte;
			last_q <= din.last_byte;
			sh_q   <= in_frame_q ? {din.data_byte, 8'h00} : {FLAG_PATTERN, 8'h00};
		end else if (adv && !stuff_q) begin
			if (seg_end) begin
				case (seg_q)
					S_OPEN:  sh_q <= {addr_q, 8'h00};
					S_ADDR:  sh_q <= {ctrl_q, 8'h00};
					S_CTRL:  sh_q <= {data_q, 8'h00};
					S_DATA:  sh_q <= crc_nx;
					S_FCS:   sh_q <= {FLAG_PATTERN, 8'h00};
					default: sh_q <= {sh_q[14:0], 1'b0};
				endcase
			end else begin
				sh_q <= {sh_q[14:0], 1'b0};
			end
		end
	end

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.frame_end |-> dout.run_last)
		else $error("frame_end without run_last");

	a_ones_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q != 3'd5 && ones_q != 3'd6 && ones_q != 3'd7)
		else $error("ones run not cleared at stuffing limit");

	a_no_stuff_in_flag: assert property (@(posedge clk) disable iff (!arst_n)
		stuff_q |-> seg_q != S_OPEN)
		else $error("stuffed bit before opening flag");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !din.ready)
		else $error("input ready right after accepting an item");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the HDLC transmit framer: predicts every line bit and checks it.
`timescale 1ns / 1ps
module testbench;
	import hdlctx_pkg::*;

	typedef struct packed {
		logic line_bit;
		logic frame_end;
		logic run_last;
	} line_item_t;

	logic clk;
	logic arst_n;

	hdlctx_in_if  in_ch();
	hdlctx_out_if out_ch();
	hdlctx_cfg_if cfg_ch();

	hdlc_transmit_framer uut (
		.clk(clk),
		.arst_n(arst_n),
		.din(in_ch),
		.dout(out_ch),
		.cfg(cfg_ch)
	);

	logic [7:0]  addr_shadow;
	logic [7:0]  ctrl_shadow;
	logic        frame_open;
	logic [2:0]  ones_count;
	logic [15:0] fcs_accum;

	line_item_t line_bits_due[$];
	line_item_t want;
	int         fail_count;
	int         hold_left;
	bit         send_gaps;
	bit         recv_gaps;
	int         items_sent;

	function automatic void queue_line_bit(input logic b, input logic fe);
		line_item_t it;
		it.line_bit  = b;
		it.frame_end = fe;
		it.run_last  = 1'b0;
		line_bits_due.push_back(it);
	endfunction

	function automatic void queue_stuffed_bit(input logic b);
		queue_line_bit(b, 1'b0);
		ones_count = b ? ones_count + 3'd1 : 3'd0;
		if (ones_count == STUFF_LIMIT) begin
			queue_line_bit(1'b0, 1'b0);
			ones_count = 3'd0;
		end
	endfunction

	function automatic void queue_flag(input logic closing);
		for (int i = 7; i >= 0; i--)
			queue_line_bit(FLAG_PATTERN[i], closing && i == 0);
	endfunction

	function automatic void queue_fcs_byte(input logic [7:0] v);
		logic [15:0] c;
		c = fcs_accum ^ {v, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		fcs_accum = c;
		for (int i = 7; i >= 0; i--)
			queue_stuffed_bit(v[i]);
	endfunction

	function automatic void predict_line_bits(input logic [7:0] d, input logic l);
		line_item_t tail;
		logic [15:0] fcs;
		if (!frame_open) begin
			fcs_accum  = CRC_INIT;
			ones_count = 3'd0;
			queue_flag(1'b0);
			queue_fcs_byte(addr_shadow);
			queue_fcs_byte(ctrl_shadow);
			frame_open = 1'b1;
		end
		queue_fcs_byte(d);
		if (l) begin
			fcs = fcs_accum;
			for (int i = 15; i >= 0; i--)
				queue_stuffed_bit(fcs[i]);
			queue_flag(1'b1);
			frame_open = 1'b0;
			ones_count = 3'd0;
			fcs_accum  = CRC_INIT;
		end
		tail = line_bits_due.pop_back();
		tail.run_last = 1'b1;
		line_bits_due.push_back(tail);
	endfunction

	task automatic send_item(input logic [7:0] d, input logic l);
		while (send_gaps && $urandom_range(0, 99) < 10) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= d;
		in_ch.last_byte <= l;
		do @(posedge clk); while (!in_ch.ready);
		predict_line_bits(d, l);
		items_sent++;
	endtask

	task automatic send_frame(input logic [7:0] bytes[$]);
		for (int i = 0; i < bytes.size(); i++)
			send_item(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic drain_line();
		in_ch.valid <= 1'b0;
		while (line_bits_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [7:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= idx;
		cfg_ch.wdata <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_ADDRESS)
			addr_shadow = v;
		else if (idx == REG_CONTROL)
			ctrl_shadow = v;
	endtask

	task automatic test_reset_values();
		send_frame('{8'h00});
		send_frame('{8'hFF, 8'hFF, 8'hFF});
		drain_line();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_ADDRESS, 8'h00);
		write_reg(REG_CONTROL, 8'h00);
		send_frame('{8'h7E});
		drain_line();
		write_reg(REG_ADDRESS, 8'hFF);
		write_reg(REG_CONTROL, 8'hFF);
		send_frame('{8'h80, 8'h01});
		drain_line();
	endtask

	task automatic test_bad_index();
		write_reg(REG_CONTROL + 8'd1, 8'h12);
		write_reg(8'hFF, 8'h34);
		send_frame('{8'h55});
		drain_line();
	endtask

	task automatic test_write_mid_frame();
		send_item(8'hAA, 1'b0);
		drain_line();
		write_reg(REG_ADDRESS, 8'h3C);
		write_reg(REG_CONTROL, 8'hC3);
		send_item(8'h0F, 1'b1);
		send_frame('{8'hF0});
		drain_line();
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		for (int i = 0; i < 10; i++)
			send_item(8'hFF ^ i[7:0], i == 9);
		drain_line();
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		logic [7:0] d;
		phase = 0;
		while (items_sent < 180) begin
			send_gaps = phase != 0;
			recv_gaps = phase != 0;
			if (phase != 0) begin
				case ($urandom_range(0, 4))
					0: begin
						write_reg(REG_ADDRESS, 8'h00);
						write_reg(REG_CONTROL, 8'hFF);
					end
					1: begin
						write_reg(REG_CONTROL, 8'h00);
						write_reg(REG_ADDRESS, 8'hFF);
					end
					2: write_reg(8'(2 + $urandom_range(0, 253)), 8'($urandom_range(0, 255)));
					default: begin
						write_reg(REG_ADDRESS, 8'($urandom_range(0, 255)));
						write_reg(REG_CONTROL, 8'($urandom_range(0, 255)));
					end
				endcase
			end
			n = phase == 0 ? 40 : $urandom_range(8, 25);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 7))
					0, 1: d = 8'hFF;
					2: d = 8'h00;
					default: d = 8'($urandom_range(0, 255));
				endcase
				send_item(d, $urandom_range(0, 3) == 0);
			end
			drain_line();
			phase++;
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (line_bits_due.size() == 0) begin
					$error("line bit %0b with no expectation waiting", out_ch.line_bit);
					fail_count++;
				end else begin
					want = line_bits_due.pop_front();
					if (out_ch.line_bit !== want.line_bit) begin
						$error("line_bit expected %0b got %0b", want.line_bit, out_ch.line_bit);
						fail_count++;
					end
					if (out_ch.frame_end !== want.frame_end) begin
						$error("frame_end expected %0b got %0b", want.frame_end,
							out_ch.frame_end);
						fail_count++;
					end
					if (out_ch.run_last !== want.run_last) begin
						$error("run_last expected %0b got %0b", want.run_last, out_ch.run_last);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= !(recv_gaps && $urandom_range(0, 99) < 10);
			end
		end
	end

	initial begin
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.data_byte <= 8'h00;
		in_ch.last_byte <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.addr     <= REG_ADDRESS;
		cfg_ch.wdata    <= 8'h00;
		addr_shadow = ADDRESS_RESET;
		ctrl_shadow = CONTROL_RESET;
		frame_open  = 1'b0;
		ones_count  = 3'd0;
		fcs_accum   = CRC_INIT;
		fail_count  = 0;
		hold_left   = 0;
		items_sent  = 0;
		send_gaps   = 1'b1;
		recv_gaps   = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_values();
		test_register_extremes();
		test_bad_index();
		test_write_mid_frame();
		test_backpressure();
		test_random_traffic();

		drain_line();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && line_bits_due.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
